// ===== rtl/core/frame_duration_ema_predictor_defines.svh =====
// assertion macros shared by the frame duration predictor rtl
// no dependencies; included by the modules that carry assertions
`ifndef FRAME_DURATION_EMA_PREDICTOR_DEFINES_SVH
`define FRAME_DURATION_EMA_PREDICTOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define FDEP_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("fdep: property violated");

// next-cycle implication, disabled while in reset
`define FDEP_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("fdep: property violated");

`endif

// ===== rtl/core/fdep_pkg.sv =====
// shared types and constants of the frame duration predictor
// no dependencies; used by fdep_ctrl, fdep_dp and the top level
package fdep_pkg;

  // field widths
  localparam int unsigned SecW    = 32;
  localparam int unsigned UsecW   = 20;
  localparam int unsigned DurW    = 32;
  localparam int unsigned AlphaW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW = 56;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_INIT_DURATION = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ALPHA_NUM     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ALPHA_DEN     = 2'd2;

  // reset values
  localparam logic [DurW-1:0]   INIT_DURATION_RST = 32'd33333;
  localparam logic [AlphaW-1:0] ALPHA_NUM_RST     = 16'd1;
  localparam logic [AlphaW-1:0] ALPHA_DEN_RST     = 16'd8;

  // interval arithmetic
  localparam logic [UsecW-1:0] USEC_PER_SEC = 20'd1000000;
  localparam int unsigned DsecW = 13;
  localparam logic signed [SecW:0] DSEC_MAX = 33'sd4095;
  localparam logic signed [SecW:0] DSEC_MIN = -33'sd4096;
  localparam logic signed [34:0] S32_MAX = 35'sd2147483647;
  localparam logic signed [34:0] S32_MIN = -35'sd2147483648;

  // divider sequencing
  localparam int unsigned DivSteps = 32;
  localparam int unsigned StepW    = 5;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic diff;
    logic scale;
    logic sat;
    logic mul_a;
    logic mul_b;
    logic sum;
    logic div_step;
    logic commit;
    logic use_avg;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic prev_zero;
  } dp_status_t;

endpackage

// ===== rtl/core/fdep_ctrl.sv =====
// sequencing state machine of the frame duration predictor
// depends on fdep_pkg and frame_duration_ema_predictor_defines.svh
`include "frame_duration_ema_predictor_defines.svh"

module fdep_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  fdep_pkg::dp_status_t status,
  output fdep_pkg::dp_cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_DIFF  = 9'b000000010,
    ST_SCALE = 9'b000000100,
    ST_SAT   = 9'b000001000,
    ST_MUL_A = 9'b000010000,
    ST_MUL_B = 9'b000100000,
    ST_SUM   = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  state_t                        state, state_next;
  logic [fdep_pkg::StepW-1:0]    step_cnt, step_cnt_next;
  logic                          skip, skip_next;
  logic                          out_valid_next;
  logic                          slot_free;

  // no request is taken while in reset
  assign in_ready  = (state == ST_IDLE) && !rst;
  assign slot_free = !out_valid || out_ready;

  // next state and commands
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    skip_next     = skip;
    cmd           = '0;
    cmd.use_avg   = skip;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        skip_next  = status.prev_zero;
        state_next = status.prev_zero ? ST_DONE : ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_SAT;
      end
      ST_SAT: begin
        cmd.sat    = 1'b1;
        state_next = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.mul_a  = 1'b1;
        state_next = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum       = 1'b1;
        step_cnt_next = '0;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == fdep_pkg::StepW'(fdep_pkg::DivSteps - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_cnt  <= '0;
      skip      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      skip      <= skip_next;
      out_valid <= out_valid_next;
    end
  end

  `FDEP_ASSERT_NEXT(a_accept_starts_diff, clk, rst, !rst && in_valid && in_ready, state == ST_DIFF)
  `FDEP_ASSERT_NEXT(a_div_ends_in_done, clk, rst, !rst && state == ST_DIV && step_cnt == fdep_pkg::StepW'(fdep_pkg::DivSteps - 1), state == ST_DONE)
  `FDEP_ASSERT_NEXT(a_commit_shows_result, clk, rst, !rst && cmd.commit, out_valid)

endmodule

// ===== rtl/core/fdep_dp.sv =====
// datapath of the frame duration predictor: registers, multiplier steps, divider
// depends on fdep_pkg and frame_duration_ema_predictor_defines.svh
`include "frame_duration_ema_predictor_defines.svh"

module fdep_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [fdep_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [fdep_pkg::DurW-1:0]           cfg_data,
  input  logic [fdep_pkg::SecW-1:0]           time_sec,
  input  logic [fdep_pkg::UsecW-1:0]          time_usec,
  input  fdep_pkg::dp_cmd_t                   cmd,
  output fdep_pkg::dp_status_t                status,
  output logic [fdep_pkg::DurW-1:0]           duration_us
);

  // configuration and state
  logic [fdep_pkg::DurW-1:0]    init_duration;
  logic [fdep_pkg::AlphaW-1:0]  alpha_num;
  logic [fdep_pkg::AlphaW-1:0]  alpha_den;
  logic [fdep_pkg::SecW-1:0]    prev_sec;
  logic [fdep_pkg::UsecW-1:0]   prev_usec;
  logic [fdep_pkg::DurW-1:0]    avg;

  // item and working registers
  logic [fdep_pkg::SecW-1:0]         sec_r;
  logic [fdep_pkg::UsecW-1:0]        usec_r;
  logic signed [fdep_pkg::DsecW-1:0] dsec_c;
  logic signed [fdep_pkg::UsecW:0]   dusec;
  logic signed [33:0]                scaled;
  logic signed [31:0]                interval;
  logic signed [48:0]                prod_a;
  logic [47:0]                       prod_b;
  logic [fdep_pkg::AlphaW-1:0]       rem;
  logic [31:0]                       nq;
  logic                              neg;

  // combinational helpers
  logic [fdep_pkg::AlphaW-1:0]  den_eff;
  logic [fdep_pkg::AlphaW-1:0]  alpha_eff;
  logic [fdep_pkg::AlphaW-1:0]  weight_b;
  logic signed [fdep_pkg::SecW:0] dsec_full;
  logic signed [34:0]           wide_int;
  logic signed [49:0]           total;
  logic [fdep_pkg::AlphaW:0]    trial;
  logic [fdep_pkg::AlphaW:0]    trial_diff;
  logic                         trial_ge;
  logic [fdep_pkg::DurW-1:0]    result;

  // effective weights: zero denominator reads as one, numerator clamped
  assign den_eff   = (alpha_den == '0) ? fdep_pkg::AlphaW'(1) : alpha_den;
  assign alpha_eff = (alpha_num > den_eff) ? den_eff : alpha_num;
  assign weight_b  = den_eff - alpha_eff;

  assign status.prev_zero = (prev_sec == '0) && (prev_usec == '0);

  // interval parts
  assign dsec_full = $signed({1'b0, sec_r}) - $signed({1'b0, prev_sec});
  assign wide_int  = $signed({scaled[33], scaled})
                   + $signed({{14{dusec[fdep_pkg::UsecW]}}, dusec});

  // blend numerator, never negative unless the interval is
  assign total = $signed({prod_a[48], prod_a}) + $signed({2'b00, prod_b});

  // restoring divider step
  assign trial      = {rem, nq[31]};
  assign trial_ge   = (trial >= {1'b0, den_eff});
  assign trial_diff = trial - {1'b0, den_eff};

  assign result = cmd.use_avg ? avg : (neg ? '0 : nq);

  // configuration and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      init_duration <= fdep_pkg::INIT_DURATION_RST;
      alpha_num     <= fdep_pkg::ALPHA_NUM_RST;
      alpha_den     <= fdep_pkg::ALPHA_DEN_RST;
      prev_sec      <= '0;
      prev_usec     <= '0;
      avg           <= fdep_pkg::INIT_DURATION_RST;
    end else begin
      if (cmd.commit) begin
        prev_sec  <= sec_r;
        prev_usec <= usec_r;
        avg       <= result;
      end
      // register writes; index out of range is ignored
      if (cfg_valid) begin
        unique case (cfg_index)
          fdep_pkg::REG_INIT_DURATION: begin
            init_duration <= cfg_data;
            avg           <= cfg_data;
          end
          fdep_pkg::REG_ALPHA_NUM: alpha_num <= cfg_data[fdep_pkg::AlphaW-1:0];
          fdep_pkg::REG_ALPHA_DEN: alpha_den <= cfg_data[fdep_pkg::AlphaW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // working registers, one arithmetic step per command
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      sec_r  <= time_sec;
      usec_r <= time_usec;
    end
    if (cmd.diff) begin
      priority if (dsec_full > fdep_pkg::DSEC_MAX) begin
        dsec_c <= fdep_pkg::DSEC_MAX[fdep_pkg::DsecW-1:0];
      end else if (dsec_full < fdep_pkg::DSEC_MIN) begin
        dsec_c <= fdep_pkg::DSEC_MIN[fdep_pkg::DsecW-1:0];
      end else begin
        dsec_c <= dsec_full[fdep_pkg::DsecW-1:0];
      end
      dusec <= $signed({1'b0, usec_r}) - $signed({1'b0, prev_usec});
    end
    if (cmd.scale) begin
      scaled <= dsec_c * $signed({1'b0, fdep_pkg::USEC_PER_SEC});
    end
    if (cmd.sat) begin
      priority if (wide_int > fdep_pkg::S32_MAX) begin
        interval <= fdep_pkg::S32_MAX[31:0];
      end else if (wide_int < fdep_pkg::S32_MIN) begin
        interval <= fdep_pkg::S32_MIN[31:0];
      end else begin
        interval <= wide_int[31:0];
      end
    end
    if (cmd.mul_a) begin
      prod_a <= $signed({1'b0, alpha_eff}) * interval;
    end
    if (cmd.mul_b) begin
      prod_b <= weight_b * avg;
    end
    // numerator below den * 2^32, so its top part is already a remainder
    if (cmd.sum) begin
      neg <= total[49];
      rem <= total[47:32];
      nq  <= total[31:0];
    end
    if (cmd.div_step) begin
      rem <= trial_ge ? trial_diff[fdep_pkg::AlphaW-1:0] : trial[fdep_pkg::AlphaW-1:0];
      nq  <= {nq[30:0], trial_ge};
    end
    if (cmd.commit) begin
      duration_us <= result;
    end
  end

  `FDEP_ASSERT_NEXT(a_rem_below_den, clk, rst, !rst && !cfg_valid && cmd.sum, neg || (rem < den_eff))
  `FDEP_ASSERT_NEXT(a_init_write_sets_avg, clk, rst, !rst && cfg_valid && cfg_index == fdep_pkg::REG_INIT_DURATION, avg == init_duration)
  `FDEP_ASSERT_NEXT(a_prev_follows_item, clk, rst, !rst && cmd.commit, prev_sec == $past(sec_r) && prev_usec == $past(usec_r))

endmodule

// ===== rtl/core/frame_duration_ema_predictor.sv =====
// Frame duration predictor: takes one presentation time (seconds and
// microseconds) per request and returns a predicted frame duration in
// microseconds as an exponential moving average with weight a/d over the
// measured interval. While the stored previous time is zero (after reset) the
// current average is returned unchanged. Otherwise an item passes through the
// steps that form the saturated interval and the two weighted products, one
// add, then the bit-serial restoring divider by d. One item is in flight at a
// time; the result sits in an output register, so the next request is taken
// while a result waits. Writing initial_duration_us also reloads the average.
// Configuration writes are accepted every cycle outside reset and must be
// made while idle.
// depends on fdep_pkg, fdep_ctrl and fdep_dp

module frame_duration_ema_predictor (
  input  logic                                clk,
  input  logic                                rst,
  // request input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fdep_pkg::InDataW-1:0]        s_axis_tdata,  // time_sec[31:0], time_usec[51:32], zero pad
  // result output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [fdep_pkg::DurW-1:0]           m_axis_tdata,  // duration_us[31:0]
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fdep_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [fdep_pkg::DurW-1:0]           cfg_data
);

  fdep_pkg::dp_cmd_t    cmd;
  fdep_pkg::dp_status_t status;

  // writes are only taken out of reset
  assign cfg_ready = !rst;

  // sequencer
  fdep_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and state
  fdep_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .time_sec    (s_axis_tdata[fdep_pkg::SecW-1:0]),
    .time_usec   (s_axis_tdata[fdep_pkg::SecW +: fdep_pkg::UsecW]),
    .cmd         (cmd),
    .status      (status),
    .duration_us (m_axis_tdata)
  );

endmodule
